### rtl/core/bhtg_pkg.sv
package bhtg_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // phase, its derivatives and the coefficients carry 32 fraction bits
  localparam int ZQ = 32;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ZONE    = 64'sh0000_0001_0000_0000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

endpackage

### rtl/core/bhtg_mul.sv
module bhtg_mul (
  input  logic                clk,
  input  logic                rst,
  input  bhtg_pkg::mul_req_t  req,
  output bhtg_pkg::mul_rsp_t  rsp
);

  logic [63:0]        ma;
  logic [63:0]        mb;
  logic               neg;
  logic [5:0]         sh;
  logic [2:0]         cnt;
  logic               busy;
  logic               done;
  logic [63:0]        pp;
  logic [1:0]         pp_pos;
  logic [127:0]       acc;
  logic signed [63:0] p;

  logic [31:0]        a_part;
  logic [31:0]        b_part;
  logic [127:0]       acc_add;
  logic [127:0]       shifted;
  logic signed [63:0] res;

  always_comb begin
    a_part  = cnt[0] ? ma[63:32] : ma[31:0];
    b_part  = cnt[1] ? mb[63:32] : mb[31:0];
    acc_add = {64'd0, pp} << {pp_pos, 5'd0};
    shifted = acc >> sh;
    if (shifted[127:64] != 64'd0 || shifted[63]) begin
      res = neg ? bhtg_pkg::S64_MIN : bhtg_pkg::S64_MAX;
    end else if (neg) begin
      res = -$signed(shifted[63:0]);
    end else begin
      res = $signed(shifted[63:0]);
    end
  end

  // four 32x32 partial products, then shift by sh, truncate toward zero, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ma   <= bhtg_pkg::mag64(req.a);
        mb   <= bhtg_pkg::mag64(req.b);
        neg  <= req.a[63] ^ req.b[63];
        sh   <= req.sh;
        acc  <= 128'd0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp     <= a_part * b_part;
          pp_pos <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt >= 3'd1 && cnt <= 3'd4) acc <= acc + acc_add;
        if (cnt == 3'd5) begin
          p    <= res;
          done <= 1'b1;
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.p    = p;

endmodule

### rtl/core/bhtg_div.sv
module bhtg_div (
  input  logic                clk,
  input  logic                rst,
  input  bhtg_pkg::div_req_t  req,
  output bhtg_pkg::div_rsp_t  rsp
);

  logic [63:0] rh;
  logic [63:0] rl;
  logic [63:0] q;
  logic [63:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;

  logic [63:0] rh_sh;
  logic        take;

  always_comb begin
    rh_sh = {rh[62:0], rl[63]};
    take  = rh[63] || (rh_sh >= den);
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.num[127:64] >= req.den) begin
          q    <= '1;
          done <= 1'b1;
        end else begin
          rh   <= req.num[127:64];
          rl   <= req.num[63:0];
          den  <= req.den;
          q    <= 64'd0;
          cnt  <= 6'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rh  <= take ? rh_sh - den : rh_sh;
        q   <= {q[62:0], take};
        rl  <= {rl[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = q;

endmodule

### rtl/core/bezier_hit_trajectory_generator_unit.sv
// channel   direction  handshake            payload
// in        request    in_valid / in_ready  command, start_x/y, hit_x/y, hit_vel_x/y
// out       result     out_valid/out_ready  status, pos_x/y, vel_x/y, acc_x/y, time_stamp
// cfg       write      cfg_we               cfg_index, cfg_data
//
// one request at a time: a tick makes thirty passes through the shared 64x64
// multiplier (four 32x32 partial products per pass); a plan makes up to five passes
// through the radix-2 divider; a rejected plan, a tick without plan or a tick past
// the stop time uses neither unit.
// rst is synchronous; a finished result waits in the output register while out_ready is low
module bezier_hit_trajectory_generator_unit #(
  parameter int FRAC_BITS  = bhtg_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = bhtg_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic signed [WORD_WIDTH-1:0] start_x,
  input  logic signed [WORD_WIDTH-1:0] start_y,
  input  logic signed [WORD_WIDTH-1:0] hit_x,
  input  logic signed [WORD_WIDTH-1:0] hit_y,
  input  logic signed [WORD_WIDTH-1:0] hit_vel_x,
  input  logic signed [WORD_WIDTH-1:0] hit_vel_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic signed [WORD_WIDTH-1:0] pos_x,
  output logic signed [WORD_WIDTH-1:0] pos_y,
  output logic signed [WORD_WIDTH-1:0] vel_x,
  output logic signed [WORD_WIDTH-1:0] vel_y,
  output logic signed [WORD_WIDTH-1:0] acc_x,
  output logic signed [WORD_WIDTH-1:0] acc_y,
  output logic [WORD_WIDTH-1:0]        time_stamp,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [WORD_WIDTH-1:0]        cfg_data
);

  localparam logic [2:0] REG_BOUND_LOW_X  = 3'd0;
  localparam logic [2:0] REG_BOUND_LOW_Y  = 3'd1;
  localparam logic [2:0] REG_BOUND_HIGH_X = 3'd2;
  localparam logic [2:0] REG_BOUND_HIGH_Y = 3'd3;
  localparam logic [2:0] REG_TIME_STEP    = 3'd4;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_POINT  = 2'd2;
  localparam logic [1:0] ST_PAST   = 2'd3;

  localparam int SH_T = bhtg_pkg::ZQ - FRAC_BITS;
  localparam logic [63:0]        WMASK64 = (64'd1 << WORD_WIDTH) - 64'd1;
  localparam logic signed [63:0] WMAX64  = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64  = -WMAX64 - 64'sd1;
  localparam logic [63:0]        TQ_LIM  = 64'(bhtg_pkg::S64_MAX) >> SH_T;
  localparam logic signed [63:0] ZONE3   = 64'sh3_0000_0000;
  localparam logic signed [63:0] ZONE4   = 64'sh4_0000_0000;
  localparam logic signed [63:0] ZONE6   = 64'sh6_0000_0000;
  localparam logic signed [63:0] ZONE12  = 64'shC_0000_0000;
  localparam logic [5:0]         SH_Z    = 6'(bhtg_pkg::ZQ);
  localparam logic [5:0]         SH_F    = 6'(FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE, S_CHECK, S_RDIV, S_OFF, S_MID, S_DIFF, S_RU, S_R2, S_R3, S_R4,
    S_TH, S_TS, S_COMMIT, S_TICK, S_T2, S_T3, S_T4, S_P1, S_P2,
    S_D1, S_D2, S_D3, S_D4, S_A1, S_A2, S_A3, S_A4, S_PHASE, S_OMP,
    S_W1, S_W2, S_DD, S_X1, S_X2, S_POS, S_X3, S_X4, S_SLOPE, S_X5, S_X6, S_X7,
    S_DONE
  } state_t;

  function automatic logic signed [WORD_WIDTH-1:0] clamp_word(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > WMAX64) c = WMAX64;
    else if (v < WMIN64) c = WMIN64;
    return c[WORD_WIDTH-1:0];
  endfunction

  state_t state;

  // configuration
  logic signed [WORD_WIDTH-1:0] bound_low_x, bound_low_y, bound_high_x, bound_high_y;
  logic [15:0]                  time_step;

  // captured request
  logic signed [WORD_WIDTH-1:0] sp [2];
  logic signed [WORD_WIDTH-1:0] hp [2];
  logic signed [WORD_WIDTH-1:0] vp [2];

  // plan state
  logic signed [WORD_WIDTH-1:0] start_point [2];
  logic signed [WORD_WIDTH-1:0] hit_point [2];
  logic signed [WORD_WIDTH-1:0] middle_point [2];
  logic signed [WORD_WIDTH-1:0] middle_stop_point [2];
  logic signed [63:0]           cubic_coeff, quartic_coeff;
  logic [WORD_WIDTH-1:0]        hit_time, stop_time, elapsed_time;
  logic                         plan_loaded;

  // working registers
  logic [63:0]        reach, md, mv;
  logic signed [63:0] off, r, tmp, tq, t2, t3, t4, pa, ph, dph, ddph, omp;
  logic signed [63:0] w1, w2, dph2, slope;
  logic               ax, seg, issued;

  // pending result
  logic [1:0]                   res_status;
  logic signed [WORD_WIDTH-1:0] res_pos [2];
  logic signed [WORD_WIDTH-1:0] res_vel [2];
  logic signed [WORD_WIDTH-1:0] res_acc [2];
  logic [WORD_WIDTH-1:0]        res_ts;

  bhtg_pkg::mul_req_t mul_req;
  bhtg_pkg::mul_rsp_t mul_rsp;
  bhtg_pkg::div_req_t div_req;
  bhtg_pkg::div_rsp_t div_rsp;

  bhtg_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  bhtg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic signed [WORD_WIDTH-1:0] lo_b, hi_b;
  logic                         reject;
  logic [63:0]                  span;
  logic                         kx;
  logic signed [63:0]           dk;
  logic [63:0]                  md_c, mv_c, md6;
  logic signed [63:0]           h64, a64, m64, b64, d_am, d_bm, d_ma, curv;
  logic [WORD_WIDTH:0]          e_sum;
  logic [WORD_WIDTH-1:0]        e_new;
  logic signed [63:0]           tq_c;
  logic                         m_use, d_use, done_now;
  logic signed [63:0]           m_a, m_b;
  logic [5:0]                   m_sh;
  logic [127:0]                 d_num;
  logic [63:0]                  d_den;

  always_comb begin
    lo_b = ax ? bound_low_y : bound_low_x;
    hi_b = ax ? bound_high_y : bound_high_x;
    reject = (sp[0] < bound_low_x) || (sp[0] > bound_high_x) ||
             (hp[0] < bound_low_x) || (hp[0] > bound_high_x) ||
             (sp[1] < bound_low_y) || (sp[1] > bound_high_y) ||
             (hp[1] < bound_low_y) || (hp[1] > bound_high_y) ||
             (vp[0] == '0 && vp[1] == '0);
    // distance from the hit point to the box edge behind the velocity
    span = vp[ax][WORD_WIDTH-1] ? 64'(64'(hi_b) - 64'(hp[ax]))
                                : 64'(64'(hp[ax]) - 64'(lo_b));
    h64  = 64'(hp[ax]);
    kx   = (vp[0] == '0);
    dk   = 64'(hp[kx]) - 64'(middle_point[kx]);
    md_c = bhtg_pkg::mag64(dk);
    mv_c = bhtg_pkg::mag64(64'(vp[kx]));
    md6  = (md << 2) + (md << 1);

    a64  = seg ? 64'(hit_point[ax]) : 64'(start_point[ax]);
    m64  = seg ? 64'(middle_stop_point[ax]) : 64'(middle_point[ax]);
    b64  = seg ? 64'(start_point[ax]) : 64'(hit_point[ax]);
    d_am = a64 - m64;
    d_bm = b64 - m64;
    d_ma = m64 - a64;
    curv = (a64 - (m64 <<< 1) + b64) <<< 1;

    e_sum = {1'b0, elapsed_time} + (WORD_WIDTH + 1)'(time_step);
    e_new = e_sum[WORD_WIDTH] ? '1 : e_sum[WORD_WIDTH-1:0];
    tq_c  = (64'(e_new) > TQ_LIM) ? bhtg_pkg::S64_MAX : $signed(64'(e_new) << SH_T);
  end

  // operand selection for the shared multiplier
  always_comb begin
    m_use = 1'b1;
    m_a   = tq;
    m_b   = tq;
    m_sh  = SH_Z;
    case (state)
      S_OFF: begin m_a = $signed(reach); m_b = 64'(vp[ax]); m_sh = SH_F; end
      S_R2:  begin m_a = r;             m_b = r;      end
      S_R3:  begin m_a = tmp;           m_b = r;      end
      S_R4:  begin m_a = tmp;           m_b = r;      end
      S_T2:  begin m_a = tq;            m_b = tq;     end
      S_T3:  begin m_a = t2;            m_b = tq;     end
      S_T4:  begin m_a = t3;            m_b = tq;     end
      S_P1:  begin m_a = cubic_coeff;   m_b = t3;     end
      S_P2:  begin m_a = quartic_coeff; m_b = t4;     end
      S_D1:  begin m_a = t2;            m_b = ZONE3;  end
      S_D2:  begin m_a = cubic_coeff;   m_b = tmp;    end
      S_D3:  begin m_a = t3;            m_b = ZONE4;  end
      S_D4:  begin m_a = quartic_coeff; m_b = tmp;    end
      S_A1:  begin m_a = tq;            m_b = ZONE6;  end
      S_A2:  begin m_a = cubic_coeff;   m_b = tmp;    end
      S_A3:  begin m_a = t2;            m_b = ZONE12; end
      S_A4:  begin m_a = quartic_coeff; m_b = tmp;    end
      S_W1:  begin m_a = omp;           m_b = omp;    end
      S_W2:  begin m_a = ph;            m_b = ph;     end
      S_DD:  begin m_a = dph;           m_b = dph;    end
      S_X1:  begin m_a = w1;            m_b = d_am;   end
      S_X2:  begin m_a = w2;            m_b = d_bm;   end
      S_X3:  begin m_a = omp;           m_b = d_ma;   end
      S_X4:  begin m_a = ph;            m_b = d_bm;   end
      S_X5:  begin m_a = slope;         m_b = dph;    end
      S_X6:  begin m_a = curv;          m_b = dph2;   end
      S_X7:  begin m_a = slope;         m_b = ddph;   end
      default: m_use = 1'b0;
    endcase
  end

  // operand selection for the divider
  always_comb begin
    d_use = 1'b1;
    d_num = 128'(span) << FRAC_BITS;
    d_den = bhtg_pkg::mag64(64'(vp[ax]));
    case (state)
      S_RDIV: d_use = (vp[ax] != '0);
      S_RU:   begin d_num = 128'(mv) << 31;              d_den = md; end
      S_TH:   begin d_num = 128'(md) << (FRAC_BITS + 2); d_den = mv; end
      S_TS:   begin d_num = 128'(md6) << FRAC_BITS;      d_den = mv; end
      default: d_use = 1'b0;
    endcase
  end

  always_comb begin
    mul_req.start = m_use && !issued;
    mul_req.a     = m_a;
    mul_req.b     = m_b;
    mul_req.sh    = m_sh;
    div_req.start = d_use && !issued;
    div_req.num   = d_num;
    div_req.den   = d_den;
    done_now      = (m_use && mul_rsp.done) || (d_use && div_rsp.done);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      out_valid    <= 1'b0;
      bound_low_x  <= '0;
      bound_low_y  <= '0;
      bound_high_x <= WORD_WIDTH'(1) << FRAC_BITS;
      bound_high_y <= WORD_WIDTH'(1) << FRAC_BITS;
      time_step    <= 16'd66;
      for (int i = 0; i < 2; i++) begin
        start_point[i]       <= '0;
        hit_point[i]         <= '0;
        middle_point[i]      <= '0;
        middle_stop_point[i] <= '0;
      end
      cubic_coeff   <= '0;
      quartic_coeff <= '0;
      hit_time      <= '0;
      stop_time     <= '0;
      elapsed_time  <= '0;
      plan_loaded   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BOUND_LOW_X:  bound_low_x  <= cfg_data;
          REG_BOUND_LOW_Y:  bound_low_y  <= cfg_data;
          REG_BOUND_HIGH_X: bound_high_x <= cfg_data;
          REG_BOUND_HIGH_Y: bound_high_y <= cfg_data;
          REG_TIME_STEP:    time_step    <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      if ((m_use || d_use) && !issued) issued <= 1'b1;
      if (done_now) issued <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sp[0] <= start_x;   sp[1] <= start_y;
            hp[0] <= hit_x;     hp[1] <= hit_y;
            vp[0] <= hit_vel_x; vp[1] <= hit_vel_y;
            res_status <= ST_PAST;
            for (int i = 0; i < 2; i++) begin
              res_pos[i] <= '0;
              res_vel[i] <= '0;
              res_acc[i] <= '0;
            end
            res_ts <= '0;
            ax     <= 1'b0;
            state  <= command ? S_TICK : S_CHECK;
          end
        end

        S_CHECK: begin
          if (reject) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else begin
            reach <= WMASK64;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (vp[ax] == '0 || done_now) begin
            if (done_now && div_rsp.q < reach) reach <= div_rsp.q;
            ax    <= ~ax;
            state <= ax ? S_OFF : S_RDIV;
          end
        end
        S_OFF: if (done_now) begin off <= mul_rsp.p; state <= S_MID; end
        S_MID: begin
          middle_point[ax]      <= clamp_word(bhtg_pkg::sub_sat(h64, off));
          middle_stop_point[ax] <= clamp_word(bhtg_pkg::add_sat(h64, off));
          start_point[ax]       <= sp[ax];
          hit_point[ax]         <= hp[ax];
          ax    <= ~ax;
          state <= ax ? S_DIFF : S_OFF;
        end
        S_DIFF: begin
          md <= md_c;
          mv <= mv_c;
          if (md_c == 64'd0) begin
            // hit point already on the box edge: degenerate but accepted
            cubic_coeff   <= '0;
            quartic_coeff <= '0;
            hit_time      <= '0;
            stop_time     <= '0;
            state         <= S_COMMIT;
          end else begin
            state <= S_RU;
          end
        end
        S_RU: if (done_now) begin
          r     <= div_rsp.q[63] ? bhtg_pkg::S64_MAX : $signed(div_rsp.q);
          state <= S_R2;
        end
        S_R2: if (done_now) begin tmp <= mul_rsp.p; state <= S_R3; end
        S_R3: if (done_now) begin
          tmp         <= mul_rsp.p;
          cubic_coeff <= mul_rsp.p >>> 2;
          state       <= S_R4;
        end
        S_R4: if (done_now) begin
          quartic_coeff <= -(mul_rsp.p >>> 4);
          state         <= S_TH;
        end
        S_TH: if (done_now) begin
          hit_time <= (div_rsp.q > WMASK64) ? '1 : div_rsp.q[WORD_WIDTH-1:0];
          state    <= S_TS;
        end
        S_TS: if (done_now) begin
          stop_time <= (div_rsp.q > WMASK64) ? '1 : div_rsp.q[WORD_WIDTH-1:0];
          state     <= S_COMMIT;
        end
        S_COMMIT: begin
          elapsed_time <= '0;
          plan_loaded  <= 1'b1;
          res_status   <= ST_ACCEPT;
          state        <= S_DONE;
        end

        S_TICK: begin
          if (!plan_loaded) begin
            state <= S_DONE;
          end else begin
            elapsed_time <= e_new;
            res_ts       <= e_new;
            tq           <= tq_c;
            state        <= (e_new > stop_time) ? S_DONE : S_T2;
          end
        end
        S_T2: if (done_now) begin t2  <= mul_rsp.p; state <= S_T3; end
        S_T3: if (done_now) begin t3  <= mul_rsp.p; state <= S_T4; end
        S_T4: if (done_now) begin t4  <= mul_rsp.p; state <= S_P1; end
        S_P1: if (done_now) begin pa  <= mul_rsp.p; state <= S_P2; end
        S_P2: if (done_now) begin
          ph    <= bhtg_pkg::add_sat(pa, mul_rsp.p);
          state <= S_D1;
        end
        S_D1: if (done_now) begin tmp <= mul_rsp.p; state <= S_D2; end
        S_D2: if (done_now) begin pa  <= mul_rsp.p; state <= S_D3; end
        S_D3: if (done_now) begin tmp <= mul_rsp.p; state <= S_D4; end
        S_D4: if (done_now) begin
          dph   <= bhtg_pkg::add_sat(pa, mul_rsp.p);
          state <= S_A1;
        end
        S_A1: if (done_now) begin tmp <= mul_rsp.p; state <= S_A2; end
        S_A2: if (done_now) begin pa  <= mul_rsp.p; state <= S_A3; end
        S_A3: if (done_now) begin tmp <= mul_rsp.p; state <= S_A4; end
        S_A4: if (done_now) begin
          ddph  <= bhtg_pkg::add_sat(pa, mul_rsp.p);
          state <= S_PHASE;
        end
        S_PHASE: begin
          // past the hit time the return curve runs with phase minus one
          if (elapsed_time <= hit_time) begin
            seg <= 1'b0;
          end else begin
            seg <= 1'b1;
            ph  <= bhtg_pkg::sub_sat(ph, bhtg_pkg::ZONE);
          end
          state <= S_OMP;
        end
        S_OMP: begin
          omp   <= bhtg_pkg::sub_sat(bhtg_pkg::ZONE, ph);
          state <= S_W1;
        end
        S_W1: if (done_now) begin w1 <= mul_rsp.p; state <= S_W2; end
        S_W2: if (done_now) begin w2 <= mul_rsp.p; state <= S_DD; end
        S_DD: if (done_now) begin
          dph2  <= mul_rsp.p;
          ax    <= 1'b0;
          state <= S_X1;
        end
        S_X1: if (done_now) begin pa <= mul_rsp.p; state <= S_X2; end
        S_X2: if (done_now) begin
          pa    <= bhtg_pkg::add_sat(pa, mul_rsp.p);
          state <= S_POS;
        end
        S_POS: begin
          res_pos[ax] <= clamp_word(bhtg_pkg::add_sat(m64, pa));
          state       <= S_X3;
        end
        S_X3: if (done_now) begin pa <= mul_rsp.p; state <= S_X4; end
        S_X4: if (done_now) begin
          slope <= bhtg_pkg::add_sat(pa, mul_rsp.p);
          state <= S_SLOPE;
        end
        S_SLOPE: begin
          slope <= bhtg_pkg::add_sat(slope, slope);
          state <= S_X5;
        end
        S_X5: if (done_now) begin
          res_vel[ax] <= clamp_word(mul_rsp.p);
          state       <= S_X6;
        end
        S_X6: if (done_now) begin pa <= mul_rsp.p; state <= S_X7; end
        S_X7: if (done_now) begin
          res_acc[ax] <= clamp_word(bhtg_pkg::add_sat(pa, mul_rsp.p));
          ax          <= ~ax;
          if (ax) begin
            res_status <= ST_POINT;
            state      <= S_DONE;
          end else begin
            state <= S_X1;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            pos_x      <= res_pos[0];
            pos_y      <= res_pos[1];
            vel_x      <= res_vel[0];
            vel_y      <= res_vel[1];
            acc_x      <= res_acc[0];
            acc_y      <= res_acc[1];
            time_stamp <= res_ts;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_unit_free: assert property (@(posedge clk) disable iff (rst)
    (mul_req.start || div_req.start) |-> (!mul_rsp.busy && !div_rsp.busy))
    else $error("arithmetic unit started while busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  a_commit_clears_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> (elapsed_time == '0 && plan_loaded))
    else $error("accepted plan did not restart time");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_REJECT) |->
      (pos_x == '0 && vel_y == '0 && acc_x == '0 && time_stamp == '0))
    else $error("rejected plan carries nonzero fields");

endmodule

### dv/bezier_hit_trajectory_generator_unit_tb.sv
`timescale 1ns / 1ps

module bezier_hit_trajectory_generator_unit_tb;
  import bhtg_pkg::*;

  localparam logic CMD_PLAN = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_POINT  = 2'd2;
  localparam logic [1:0] ST_PAST   = 2'd3;

  localparam logic [2:0] REG_LOW_X  = 3'd0;
  localparam logic [2:0] REG_LOW_Y  = 3'd1;
  localparam logic [2:0] REG_HIGH_X = 3'd2;
  localparam logic [2:0] REG_HIGH_Y = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;

  localparam int FB = 16;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint UNIT_Q32 = 64'sh0000_0001_0000_0000;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;
  localparam logic [63:0] W_MASK = 64'h0000_0000_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic [1:0]  st;
    int          px, py, vx, vy, ax, ay;
    logic [31:0] ts;
  } traj_point_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_PLAN;
  logic signed [31:0] start_x = '0, start_y = '0, hit_x = '0, hit_y = '0;
  logic signed [31:0] hit_vel_x = '0, hit_vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [31:0] time_stamp;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LOW_X;
  logic [31:0] cfg_data = '0;

  bezier_hit_trajectory_generator_unit u_top (.*);

  // predictor state
  longint box_lo[2], box_hi[2];
  logic [15:0] step_q;
  longint p_start[2], p_hit[2], p_mid[2], p_mids[2];
  longint coef3, coef4;
  logic [63:0] t_hit, t_stop, t_now;
  bit have_plan;

  traj_point_t pending_points[$];
  int errors = 0;
  int cycles = 0;
  bit hold_req = 0;
  bit no_gaps = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** bezier_hit_trajectory_generator_unit: FAILED **");
      $finish;
    end
  end

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] abs_u(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // exact product, shifted toward zero, saturated
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = {64'b0, abs_u(a)} * {64'b0, abs_u(b)};
    p = p >> sh;
    if (neg) begin
      if (p >= (128'd1 << 63)) return I64_MIN;
      return -longint'(p[63:0]);
    end
    if (p > 128'(I64_MAX)) return I64_MAX;
    return longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] den);
    logic [127:0] q;
    q = ({64'b0, a} * {64'b0, b}) / {64'b0, den};
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic longint clamp_w(longint v);
    return v > W_MAX ? W_MAX : (v < W_MIN ? W_MIN : v);
  endfunction

  function automatic traj_point_t plan_trajectory(longint s[2], longint h[2], longint v[2]);
    traj_point_t res;
    logic [63:0] reach, q, md, mv, ru, th, tsv;
    longint off, mid[2], mids[2], r, r3, r4, d;
    int k;
    res = '{ST_REJECT, 0, 0, 0, 0, 0, 0, 0};
    if (v[0] == 0 && v[1] == 0) return res;
    for (int ax = 0; ax < 2; ax++)
      if (s[ax] < box_lo[ax] || s[ax] > box_hi[ax] || h[ax] < box_lo[ax] || h[ax] > box_hi[ax])
        return res;
    reach = W_MASK;
    for (int ax = 0; ax < 2; ax++) begin
      if (v[ax] != 0) begin
        if (v[ax] > 0) q = scaled_quot(64'(h[ax] - box_lo[ax]), 64'd1 << FB, abs_u(v[ax]));
        else q = scaled_quot(64'(box_hi[ax] - h[ax]), 64'd1 << FB, abs_u(v[ax]));
        if (q < reach) reach = q;
      end
    end
    for (int ax = 0; ax < 2; ax++) begin
      off = fx_mul(longint'(reach), v[ax], FB);
      mid[ax] = clamp_w(sat_sub(h[ax], off));
      mids[ax] = clamp_w(sat_add(h[ax], off));
      p_start[ax] = s[ax];
      p_hit[ax] = h[ax];
      p_mid[ax] = mid[ax];
      p_mids[ax] = mids[ax];
    end
    k = v[0] != 0 ? 0 : 1;
    d = h[k] - mid[k];
    md = abs_u(d);
    mv = abs_u(v[k]);
    if (md == 0) begin
      coef3 = 0; coef4 = 0; t_hit = 0; t_stop = 0;
    end else begin
      ru = scaled_quot(mv, 64'd1 << 31, md);
      r = ru > 64'(I64_MAX) ? I64_MAX : longint'(ru);
      r3 = fx_mul(fx_mul(r, r, 32), r, 32);
      r4 = fx_mul(r3, r, 32);
      th = scaled_quot(md, 64'd4 << FB, mv);
      tsv = scaled_quot(md, 64'd6 << FB, mv);
      coef3 = r3 >>> 2;
      coef4 = -(r4 >>> 4);
      t_hit = th > W_MASK ? W_MASK : th;
      t_stop = tsv > W_MASK ? W_MASK : tsv;
    end
    t_now = 0;
    have_plan = 1;
    res.st = ST_ACCEPT;
    return res;
  endfunction

  function automatic traj_point_t sample_trajectory();
    traj_point_t res;
    longint tq, t2, t3, t4, ph, dph, ddph, omp, w1, w2, dph2;
    longint a[2], m[2], b[2], pos, slope, curv, vel, acc;
    res = '{ST_PAST, 0, 0, 0, 0, 0, 0, 0};
    if (!have_plan) return res;
    t_now = t_now + step_q;
    if (t_now > W_MASK) t_now = W_MASK;
    res.ts = t_now[31:0];
    if (t_now > t_stop) return res;
    tq = longint'(t_now << (32 - FB));
    t2 = fx_mul(tq, tq, 32);
    t3 = fx_mul(t2, tq, 32);
    t4 = fx_mul(t3, tq, 32);
    ph = sat_add(fx_mul(coef3, t3, 32), fx_mul(coef4, t4, 32));
    dph = sat_add(fx_mul(coef3, fx_mul(t2, 3 * UNIT_Q32, 32), 32),
                  fx_mul(coef4, fx_mul(t3, 4 * UNIT_Q32, 32), 32));
    ddph = sat_add(fx_mul(coef3, fx_mul(tq, 6 * UNIT_Q32, 32), 32),
                   fx_mul(coef4, fx_mul(t2, 12 * UNIT_Q32, 32), 32));
    if (t_now <= t_hit) begin
      a = p_start; m = p_mid; b = p_hit;
    end else begin
      // return leg runs hit -> start with the phase shifted down by one
      ph = sat_sub(ph, UNIT_Q32);
      a = p_hit; m = p_mids; b = p_start;
    end
    omp = sat_sub(UNIT_Q32, ph);
    w1 = fx_mul(omp, omp, 32);
    w2 = fx_mul(ph, ph, 32);
    dph2 = fx_mul(dph, dph, 32);
    for (int ax = 0; ax < 2; ax++) begin
      pos = sat_add(m[ax], sat_add(fx_mul(w1, a[ax] - m[ax], 32), fx_mul(w2, b[ax] - m[ax], 32)));
      slope = sat_add(fx_mul(omp, m[ax] - a[ax], 32), fx_mul(ph, b[ax] - m[ax], 32));
      slope = sat_add(slope, slope);
      curv = 2 * (a[ax] - 2 * m[ax] + b[ax]);
      vel = fx_mul(slope, dph, 32);
      acc = sat_add(fx_mul(curv, dph2, 32), fx_mul(slope, ddph, 32));
      if (ax == 0) begin
        res.px = int'(clamp_w(pos)); res.vx = int'(clamp_w(vel)); res.ax = int'(clamp_w(acc));
      end else begin
        res.py = int'(clamp_w(pos)); res.vy = int'(clamp_w(vel)); res.ay = int'(clamp_w(acc));
      end
    end
    res.st = ST_POINT;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // one request; returns at the edge where it was taken, valid still high
  task automatic send_request(logic cmd, int sx, int sy, int hx, int hy, int vx, int vy);
    int gap;
    longint s[2], h[2], v[2];
    gap = no_gaps ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    start_x <= sx; start_y <= sy; hit_x <= hx; hit_y <= hy;
    hit_vel_x <= vx; hit_vel_y <= vy;
    s = '{sx, sy}; h = '{hx, hy}; v = '{vx, vy};
    if (cmd == CMD_PLAN) pending_points.push_back(plan_trajectory(s, h, v));
    else pending_points.push_back(sample_trajectory());
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(int lx, int ly, int hx, int hy, logic [15:0] stp);
    logic [31:0] vals[5];
    vals = '{lx, ly, hx, hy, {16'b0, stp}};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_lo = '{lx, ly};
    box_hi = '{hx, hy};
    step_q = stp;
  endtask

  function automatic int pick_in(longint lo, longint hi);
    logic [63:0] r;
    case ($urandom_range(0, 7))
      0: return int'(lo);
      1: return int'(hi);
      default: begin
        r = {$urandom, $urandom};
        return int'(lo + longint'(r % 64'(hi - lo + 1)));
      end
    endcase
  endfunction

  function automatic int pick_vel();
    int v;
    v = $signed($urandom) >>> $urandom_range(0, 31);
    return v == 0 ? 1 : v;
  endfunction

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int n;
    traj_point_t got, want;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 0;
      end else begin
        n = no_gaps ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17));
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = '{status, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, time_stamp};
      @(posedge clk);
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result status", got.st, -1);
      end else begin
        want = pending_points.pop_front();
        if (got.st != want.st) report_mismatch("status", got.st, want.st);
        if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
        if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
        if (got.vx != want.vx) report_mismatch("vel_x", got.vx, want.vx);
        if (got.vy != want.vy) report_mismatch("vel_y", got.vy, want.vy);
        if (got.ax != want.ax) report_mismatch("acc_x", got.ax, want.ax);
        if (got.ay != want.ay) report_mismatch("acc_y", got.ay, want.ay);
        if (got.ts != want.ts) report_mismatch("time_stamp", got.ts, want.ts);
      end
    end
  end

  task automatic test_directed();
    // no plan yet
    send_ticks(2);
    // default box, plain plan and three ticks
    send_request(CMD_PLAN, 0, 0, 32768, 32768, 65536, 0);
    send_ticks(3);
    drain();
    write_regs(0, 0, 65536, 65536, 16'd65535);
    send_request(CMD_PLAN, 0, 65536, 32768, 16384, 0, -65536);
    send_ticks(8);
    // rejects: outside box, zero velocity; old plan keeps running
    send_request(CMD_PLAN, -1, 0, 0, 0, 65536, 0);
    send_request(CMD_PLAN, 0, 0, 65537, 0, 65536, 0);
    send_request(CMD_PLAN, 0, 0, 0, 0, 0, 0);
    send_ticks(1);
    // hit on the box edge along the velocity: no motion, still accepted
    send_request(CMD_PLAN, 65536, 65536, 0, 32768, 65536, 0);
    send_ticks(1);
    drain();
    // full range box with extreme points and velocities
    write_regs(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd1);
    send_request(CMD_PLAN, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_ticks(2);
    send_request(CMD_PLAN, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 1);
    send_ticks(2);
    drain();
    // inverted box rejects everything
    write_regs(65536, 65536, 0, 0, 16'd66);
    send_request(CMD_PLAN, 0, 0, 0, 0, 65536, 65536);
    send_ticks(1);
    drain();
  endtask

  // elapsed time runs into saturation past the stop time
  task automatic test_time_saturation();
    write_regs(0, 0, 65536, 65536, 16'd65535);
    send_request(CMD_PLAN, 0, 0, 0, 0, 65536, 0);
    no_gaps = 1;
    send_ticks(65540);
    drain();
    no_gaps = 0;
  endtask

  task automatic test_random_plans();
    int a, b, lx, ly, hx, hy, n, sx, sy, ex, ey;
    logic [15:0] stp;
    logic [63:0] need;
    for (int ph = 0; ph < 8; ph++) begin
      a = $signed($urandom) >>> $urandom_range(0, 16);
      b = $signed($urandom) >>> $urandom_range(0, 16);
      lx = a < b ? a : b; hx = a < b ? b : a;
      a = $signed($urandom) >>> $urandom_range(0, 16);
      b = $signed($urandom) >>> $urandom_range(0, 16);
      ly = a < b ? a : b; hy = a < b ? b : a;
      if (ph == 0) begin
        lx = 32'sh8000_0000; ly = 32'sh8000_0000; hx = 32'sh7FFF_FFFF; hy = 32'sh7FFF_FFFF;
      end
      case (ph % 4)
        0: stp = 16'd65535;
        1: stp = 16'd1;
        default: stp = 16'($urandom_range(1, 65535));
      endcase
      write_regs(lx, ly, hx, hy, stp);
      for (int sq = 0; sq < 7; sq++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(CMD_PLAN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          sx = pick_in(lx, hx); sy = pick_in(ly, hy);
          ex = pick_in(lx, hx); ey = pick_in(ly, hy);
          case ($urandom_range(0, 3))
            0: send_request(CMD_PLAN, sx, sy, ex, ey, pick_vel(), 0);
            1: send_request(CMD_PLAN, sx, sy, ex, ey, 0, pick_vel());
            default: send_request(CMD_PLAN, sx, sy, ex, ey, pick_vel(), pick_vel());
          endcase
        end
        need = t_stop / step_q + 2;
        n = need > 14 ? 14 : int'(need);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
        send_ticks(n);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_regs(0, 0, 65536, 65536, 16'd4096);
    hold_req = 1;
    no_gaps = 1;
    send_request(CMD_PLAN, 0, 0, 40000, 50000, 70000, -30000);
    send_ticks(8);
    no_gaps = 0;
    drain();
  endtask

  initial begin
    box_lo = '{0, 0};
    box_hi = '{65536, 65536};
    step_q = 16'd66;
    p_start = '{0, 0}; p_hit = '{0, 0}; p_mid = '{0, 0}; p_mids = '{0, 0};
    coef3 = 0; coef4 = 0; t_hit = 0; t_stop = 0; t_now = 0; have_plan = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_plans();
    test_time_saturation();
    if (errors == 0) $display("** bezier_hit_trajectory_generator_unit: PASSED **");
    else $display("** bezier_hit_trajectory_generator_unit: FAILED **");
    $finish;
  end

endmodule
